// File: rtl/id3p_pkg.sv
// Types, constants and helper functions shared by the tag frame parser.
package id3p_pkg;

   // Event kinds carried on the result channel.
   localparam logic [2:0] EV_FRAME_START = 3'd0;
   localparam logic [2:0] EV_ENCODING    = 3'd1;
   localparam logic [2:0] EV_LANGUAGE    = 3'd2;
   localparam logic [2:0] EV_TEXT        = 3'd3;
   localparam logic [2:0] EV_FRAME_DONE  = 3'd4;
   localparam logic [2:0] EV_TAG_STATUS  = 3'd5;

   // Frame classes.
   localparam logic [2:0] CL_OTHER   = 3'd0;
   localparam logic [2:0] CL_TITLE   = 3'd1;
   localparam logic [2:0] CL_ARTIST  = 3'd2;
   localparam logic [2:0] CL_ALBUM   = 3'd3;
   localparam logic [2:0] CL_YEAR    = 3'd4;
   localparam logic [2:0] CL_COMMENT = 3'd5;
   localparam logic [2:0] CL_GENRE   = 3'd6;

   // Tag status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_TAG    = 2'd1;
   localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
   localparam logic [1:0] ST_NO_FRAMES = 2'd3;

   // Frame identifiers, big-endian ASCII.
   localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
   localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
   localparam logic [31:0] ID_TALB = 32'h5441_4C42;
   localparam logic [31:0] ID_TYER = 32'h5459_4552;
   localparam logic [31:0] ID_COMM = 32'h434F_4D4D;
   localparam logic [31:0] ID_TCON = 32'h5443_4F4E;

   // Tag header magic bytes.
   localparam logic [7:0] MAGIC_0 = 8'h49;
   localparam logic [7:0] MAGIC_1 = 8'h44;
   localparam logic [7:0] MAGIC_2 = 8'h33;

   // Register map.
   localparam logic REG_MAX_FRAME = 1'b0;
   localparam logic REG_MAX_TAG   = 1'b1;

   localparam logic [30:0] MAX_FRAME_RESET = 31'd10485760;
   localparam logic [27:0] MAX_TAG_RESET   = 28'd104857600;

   localparam logic [30:0] MAX_SIZE_MASK = 31'h7FFF_FFFF;

   // One result word.
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] frame_tag;
      logic [30:0] frame_bytes;
      logic [2:0]  frame_class;
      logic [7:0]  char_value;
      logic [1:0]  tag_status;
      logic        last;
   } rsp_type;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // First byte must be a capital letter; later bytes capitals or digits up to the first zero.
   function automatic logic id_ok(input logic [31:0] id);
      logic       ok;
      logic       stop;
      logic [7:0] c;
      ok   = is_upper(id[31:24]);
      stop = 1'b0;
      for (int i = 1; i < 4; i++) begin
         c = id[31-8*i -: 8];
         if (!stop) begin
            if (c == 8'h00) begin
               stop = 1'b1;
            end else if (!(is_upper(c) || is_digit(c))) begin
               ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   // Bytes after the first zero byte read as zero.
   function automatic logic [31:0] id_value(input logic [31:0] id);
      logic [31:0] v;
      logic        zero;
      logic [7:0]  c;
      v    = '0;
      zero = 1'b0;
      for (int i = 0; i < 4; i++) begin
         c = zero ? 8'h00 : id[31-8*i -: 8];
         if (c == 8'h00) begin
            zero = 1'b1;
         end
         v[31-8*i -: 8] = c;
      end
      return v;
   endfunction

   function automatic logic [2:0] class_of(input logic [31:0] id);
      logic [2:0] cls;
      case (id)
         ID_TIT2: cls = CL_TITLE;
         ID_TPE1: cls = CL_ARTIST;
         ID_TALB: cls = CL_ALBUM;
         ID_TYER: cls = CL_YEAR;
         ID_COMM: cls = CL_COMMENT;
         ID_TCON: cls = CL_GENRE;
         default: cls = CL_OTHER;
      endcase
      return cls;
   endfunction

endpackage

// File: rtl/id3v2_tag_frame_parser_top.sv
// Top level of the tag frame parser: input register, per-byte parse logic and result queue.
// The parser takes one file byte per clock unless the result queue stalls it. Each accepted
// byte is held in an input register, parsed against the tag and frame state, and its zero to
// three result words are written into a four-entry result queue that feeds the rsp channel.
// A new byte is taken whenever the queue holds at most one word, so the block sustains one
// byte per cycle as long as each byte yields at most one result and the consumer keeps
// rsp_tready high; a byte that yields two or three results (last payload byte, tag end, end
// of file) stalls the next byte until the queue is down to one word. Configuration should be
// taken through the csr port only while the parser is idle; the block does not enforce this.
module id3v2_tag_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] file_byte
   input  logic        req_tlast,   // end_of_file
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [31:0] frame_tag, [62:32] frame_bytes,
                                    // [65:63] frame_class, [73:66] char_value,
                                    // [75:74] tag_status, [79:76] zero
   output logic [2:0]  rsp_tuser,   // [2:0] event_kind
   output logic        rsp_tlast,   // last
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import id3p_pkg::*;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_HUNT,
      PH_FLAGS,
      PH_PAYLOAD,
      PH_DONE
   } phase_type;

   // Configuration registers.
   logic [30:0] max_frame_ff;
   logic [27:0] max_tag_ff;
   logic        csr_write;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;
   logic       go;

   // Parse state.
   phase_type   phase_ff, phase_in;
   logic [31:0] offset_ff, offset_in;
   logic [27:0] tag_size_ff, tag_size_in;
   logic [7:0]  window_ff [8];
   logic [7:0]  window_in [8];
   logic [2:0]  fill_ff, fill_in;
   logic [31:0] cur_tag_ff, cur_tag_in;
   logic [2:0]  cur_class_ff, cur_class_in;
   logic [30:0] frame_size_ff, frame_size_in;
   logic [30:0] payload_left_ff, payload_left_in;
   logic [2:0]  payload_index_ff, payload_index_in;
   logic        recorded_ff, recorded_in;

   // Result candidates of the current byte.
   rsp_type     main_ev, done_ev, stat_ev;
   logic        main_vld, done_vld, stat_vld;
   rsp_type     slots [3];
   logic [1:0]  slot_cnt;

   // Helper values.
   logic [31:0] win_id;
   logic [31:0] win_size;
   logic [28:0] tag_end;
   logic        comm_long;

   // Result queue.
   rsp_type     queue_ff [QUEUE_DEPTH];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff;
   logic        pop;
   logic [1:0]  push_n;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= MAX_FRAME_RESET;
         max_tag_ff   <= MAX_TAG_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_MAX_FRAME) begin
            max_frame_ff <= csr_pwdata[30:0];
         end else begin
            max_tag_ff <= csr_pwdata[27:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_MAX_FRAME) begin
         csr_prdata = {1'b0, max_frame_ff};
      end else begin
         csr_prdata = {4'b0, max_tag_ff};
      end
   end

   // ---------------- input register ----------------
   assign go         = in_valid_ff && (count_ff <= 3'd1);
   assign req_tready = !in_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eof_ff  <= req_tlast;
      end
   end

   // ---------------- per-byte parse ----------------
   // The window is a shift line with the newest byte at the highest index.
   always_comb begin
      for (int i = 0; i < 7; i++) begin
         window_in[i] = window_ff[i+1];
      end
      window_in[7] = in_byte_ff;
   end

   assign win_id    = {window_in[0], window_in[1], window_in[2], window_in[3]};
   assign win_size  = {window_in[4], window_in[5], window_in[6], window_in[7]};
   assign tag_end   = 29'd10 + {1'b0, tag_size_ff};
   assign comm_long = (cur_class_ff == CL_COMMENT) && (frame_size_ff >= 31'd4);

   always_comb begin
      phase_in         = phase_ff;
      offset_in        = (offset_ff == 32'hFFFF_FFFF) ? offset_ff : offset_ff + 32'd1;
      tag_size_in      = tag_size_ff;
      fill_in          = fill_ff;
      cur_tag_in       = cur_tag_ff;
      cur_class_in     = cur_class_ff;
      frame_size_in    = frame_size_ff;
      payload_left_in  = payload_left_ff;
      payload_index_in = payload_index_ff;
      recorded_in      = recorded_ff;

      main_vld = 1'b0;
      done_vld = 1'b0;
      stat_vld = 1'b0;
      main_ev  = '0;
      done_ev  = '0;
      stat_ev  = '0;
      stat_ev.kind = EV_TAG_STATUS;

      done_ev.kind        = EV_FRAME_DONE;
      done_ev.frame_tag   = cur_tag_ff;
      done_ev.frame_bytes = frame_size_ff;
      done_ev.frame_class = cur_class_ff;

      case (phase_ff)
         PH_HEAD: begin
            if (offset_ff < 32'd3) begin
               if ((offset_ff[1:0] == 2'd0 && in_byte_ff != MAGIC_0) ||
                   (offset_ff[1:0] == 2'd1 && in_byte_ff != MAGIC_1) ||
                   (offset_ff[1:0] == 2'd2 && in_byte_ff != MAGIC_2)) begin
                  stat_vld           = 1'b1;
                  stat_ev.tag_status = ST_NO_TAG;
                  phase_in           = PH_DONE;
               end
            end else if (offset_ff >= 32'd6) begin
               tag_size_in = {tag_size_ff[20:0], in_byte_ff[6:0]};
            end
            if (offset_ff == 32'd9) begin
               if (tag_size_in == 28'd0 || tag_size_in > max_tag_ff) begin
                  stat_vld           = 1'b1;
                  stat_ev.tag_status = ST_BAD_SIZE;
                  phase_in           = PH_DONE;
               end else begin
                  phase_in = PH_HUNT;
                  fill_in  = 3'd0;
               end
            end
         end
         PH_HUNT: begin
            if (fill_ff == 3'd7) begin
               if (id_ok(win_id) && win_size != 32'd0 && !win_size[31] &&
                   win_size[30:0] <= max_frame_ff) begin
                  cur_tag_in          = id_value(win_id);
                  cur_class_in        = class_of(cur_tag_in);
                  frame_size_in       = win_size[30:0];
                  payload_left_in     = win_size[30:0];
                  payload_index_in    = 3'd0;
                  main_vld            = 1'b1;
                  main_ev.kind        = EV_FRAME_START;
                  main_ev.frame_tag   = cur_tag_in;
                  main_ev.frame_bytes = win_size[30:0];
                  main_ev.frame_class = cur_class_in;
                  phase_in            = PH_FLAGS;
                  fill_in             = 3'd0;
               end else if (offset_ff - 32'd6 >= {3'd0, tag_end}) begin
                  // The next window would start at or past the tag end.
                  stat_vld           = 1'b1;
                  stat_ev.tag_status = recorded_ff ? ST_OK : ST_NO_FRAMES;
                  phase_in           = PH_DONE;
               end
            end else begin
               fill_in = fill_ff + 3'd1;
            end
         end
         PH_FLAGS: begin
            if (fill_ff == 3'd1) begin
               fill_in  = 3'd0;
               phase_in = PH_PAYLOAD;
            end else begin
               fill_in = fill_ff + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            main_ev.frame_tag   = cur_tag_ff;
            main_ev.frame_bytes = frame_size_ff;
            main_ev.frame_class = cur_class_ff;
            main_ev.char_value  = in_byte_ff;
            if (comm_long) begin
               main_vld = 1'b1;
               if (payload_index_ff == 3'd0) begin
                  main_ev.kind = EV_ENCODING;
               end else if (payload_index_ff < 3'd4) begin
                  main_ev.kind = EV_LANGUAGE;
               end else begin
                  main_ev.kind = EV_TEXT;
               end
            end else if (cur_class_ff != CL_OTHER) begin
               if (payload_index_ff == 3'd0) begin
                  main_vld     = 1'b1;
                  main_ev.kind = EV_ENCODING;
               end else if (in_byte_ff != 8'h00) begin
                  main_vld     = 1'b1;
                  main_ev.kind = EV_TEXT;
               end
            end
            // The index only needs to tell apart the first four payload bytes.
            payload_index_in = (payload_index_ff == 3'd4) ? payload_index_ff
                                                          : payload_index_ff + 3'd1;
            payload_left_in  = payload_left_ff - 31'd1;
            if (payload_left_ff == 31'd1) begin
               done_vld    = 1'b1;
               recorded_in = 1'b1;
               phase_in    = PH_HUNT;
               fill_in     = 3'd0;
               if ({1'b0, offset_ff} + 33'd1 >= {4'd0, tag_end}) begin
                  stat_vld           = 1'b1;
                  stat_ev.tag_status = ST_OK;
                  phase_in           = PH_DONE;
               end
            end
         end
         default: begin
         end
      endcase

      if (in_eof_ff) begin
         if (phase_in == PH_HEAD) begin
            stat_vld           = 1'b1;
            stat_ev.tag_status = ST_NO_TAG;
         end else if (phase_in != PH_DONE) begin
            stat_vld           = 1'b1;
            stat_ev.tag_status = recorded_in ? ST_OK : ST_NO_FRAMES;
         end
         phase_in         = PH_HEAD;
         offset_in        = '0;
         tag_size_in      = '0;
         fill_in          = '0;
         cur_tag_in       = '0;
         cur_class_in     = '0;
         frame_size_in    = '0;
         payload_left_in  = '0;
         payload_index_in = '0;
         recorded_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEAD;
         offset_ff        <= '0;
         tag_size_ff      <= '0;
         fill_ff          <= '0;
         cur_tag_ff       <= '0;
         cur_class_ff     <= '0;
         frame_size_ff    <= '0;
         payload_left_ff  <= '0;
         payload_index_ff <= '0;
         recorded_ff      <= 1'b0;
      end else if (go) begin
         phase_ff         <= phase_in;
         offset_ff        <= offset_in;
         tag_size_ff      <= tag_size_in;
         fill_ff          <= fill_in;
         cur_tag_ff       <= cur_tag_in;
         cur_class_ff     <= cur_class_in;
         frame_size_ff    <= frame_size_in;
         payload_left_ff  <= payload_left_in;
         payload_index_ff <= payload_index_in;
         recorded_ff      <= recorded_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         for (int i = 0; i < 8; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   // Pack the valid candidates in order: payload or start word, frame done, status.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         slots[i] = '0;
      end
      slot_cnt = 2'd0;
      if (main_vld) begin
         slots[slot_cnt] = main_ev;
         slot_cnt        = slot_cnt + 2'd1;
      end
      if (done_vld) begin
         slots[slot_cnt] = done_ev;
         slot_cnt        = slot_cnt + 2'd1;
      end
      if (stat_vld) begin
         slots[slot_cnt] = stat_ev;
         slot_cnt        = slot_cnt + 2'd1;
      end
      if (slot_cnt != 2'd0) begin
         slots[slot_cnt - 2'd1].last = 1'b1;
      end
   end

   // ---------------- result queue ----------------
   assign pop    = rsp_tvalid && rsp_tready;
   assign push_n = go ? slot_cnt : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_n;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         count_ff  <= count_ff + {1'b0, push_n} - {2'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_n) begin
            queue_ff[wr_ptr_ff + 2'(i)] <= slots[i];
         end
      end
   end

   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;
   assign rsp_tdata  = {4'b0,
                        queue_ff[rd_ptr_ff].tag_status,
                        queue_ff[rd_ptr_ff].char_value,
                        queue_ff[rd_ptr_ff].frame_class,
                        queue_ff[rd_ptr_ff].frame_bytes,
                        queue_ff[rd_ptr_ff].frame_tag};

`ifndef SYNTHESIS
   // The queue never holds more words than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // A status word ends the tag: the parser is then done or back at a new file.
   assert property (@(posedge clock) disable iff (reset)
      (go && stat_vld) |=> (phase_ff == PH_DONE || phase_ff == PH_HEAD))
      else $error("parser kept running after a status word");

   // While a payload is being read, at least one payload byte remains.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (payload_left_ff != 31'd0))
      else $error("payload phase with nothing left to read");
`endif

endmodule

// File: tb/id3v2_tag_frame_parser_top_tb.sv
// Self-checking testbench for the tag frame parser: directed header cases, then random files.
module id3v2_tag_frame_parser_top_tb;
   import id3p_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_BYTES = 64;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [2:0] {P_HEADER, P_HUNT, P_FLAGS, P_PAYLOAD, P_DONE} parse_phase_t;

   typedef struct packed {
      logic [7:0] data;
      logic       eof;
      logic       typed;
      logic [1:0] status;
   } dir_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] file_byte
   logic        req_tlast;    // end_of_file
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;    // [31:0] frame_tag, [62:32] frame_bytes, [65:63] frame_class,
                              // [73:66] char_value, [75:74] tag_status, [79:76] zero
   logic [2:0]  rsp_tuser;    // [2:0] event_kind
   logic        rsp_tlast;    // last
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   id3v2_tag_frame_parser_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Parser state as predicted by the testbench.
   logic [30:0]  max_frame;
   logic [27:0]  max_tag;
   parse_phase_t parse_phase;
   logic [31:0]  file_pos;
   logic [27:0]  tag_len;
   logic [7:0]   hdr_win [8];
   logic [3:0]   win_fill;
   logic [31:0]  cur_tag;
   logic [2:0]   cur_class;
   logic [31:0]  payload_left;
   logic [31:0]  payload_idx;
   logic         frame_recorded;

   rsp_type     byte_events[$];
   rsp_type     expected_events[$];
   logic [7:0]  tag_body[$];
   logic [7:0]  file_bytes[$];
   dir_row_t    directed_rows [24];

   int unsigned mismatches;
   int unsigned words_checked;
   int unsigned frames_done;
   int unsigned files_sent;
   int unsigned bytes_sent;
   int unsigned live_bytes;
   int unsigned cycle_count;
   int unsigned stall_count;
   int          src_idle_pct;
   int          sink_idle_pct;
   logic        sink_hold;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void restart_file();
      parse_phase    = P_HEADER;
      file_pos       = '0;
      tag_len        = '0;
      win_fill       = '0;
      cur_tag        = '0;
      cur_class      = CL_OTHER;
      payload_left   = '0;
      payload_idx    = '0;
      frame_recorded = 1'b0;
      foreach (hdr_win[k]) hdr_win[k] = 8'h00;
   endfunction

   function automatic void add_event(input logic [2:0] kind, input logic [31:0] ftag,
                                     input logic [30:0] nbytes, input logic [2:0] cls,
                                     input logic [7:0] ch, input logic [1:0] st);
      rsp_type ev;
      if (byte_events.size() < 3) begin
         ev.kind        = kind;
         ev.frame_tag   = ftag;
         ev.frame_bytes = nbytes;
         ev.frame_class = cls;
         ev.char_value  = ch;
         ev.tag_status  = st;
         ev.last        = 1'b0;
         byte_events.push_back(ev);
      end
   endfunction

   function automatic void close_tag(input logic [1:0] st);
      add_event(EV_TAG_STATUS, '0, '0, CL_OTHER, 8'h00, st);
      parse_phase = P_DONE;
   endfunction

   function automatic logic [1:0] end_status();
      return frame_recorded ? ST_OK : ST_NO_FRAMES;
   endfunction

   // The first ID byte must be a capital letter; later ones capitals or digits until a zero.
   function automatic logic hdr_id_valid();
      logic ok;
      logic ended;
      ok    = (hdr_win[0] >= "A") && (hdr_win[0] <= "Z");
      ended = 1'b0;
      for (int k = 1; k < 4; k++) begin
         if (hdr_win[k] == 8'h00) begin
            ended = 1'b1;
         end else if (!ended && !((hdr_win[k] >= "A" && hdr_win[k] <= "Z") ||
                                  (hdr_win[k] >= "0" && hdr_win[k] <= "9"))) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [31:0] hdr_id_word();
      logic [31:0] w;
      logic        ended;
      w     = '0;
      ended = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (hdr_win[k] == 8'h00) ended = 1'b1;
         if (!ended) w[31-8*k -: 8] = hdr_win[k];
      end
      return w;
   endfunction

   function automatic logic [2:0] id_to_class(input logic [31:0] id);
      if (id == ID_TIT2) return CL_TITLE;
      if (id == ID_TPE1) return CL_ARTIST;
      if (id == ID_TALB) return CL_ALBUM;
      if (id == ID_TYER) return CL_YEAR;
      if (id == ID_COMM) return CL_COMMENT;
      if (id == ID_TCON) return CL_GENRE;
      return CL_OTHER;
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic eof);
      logic [31:0] pos;
      logic [31:0] fsize;
      logic [31:0] total;
      logic [63:0] tag_stop;
      logic [2:0]  kind;
      byte_events.delete();
      pos = file_pos;
      if (file_pos != 32'hFFFF_FFFF) file_pos = file_pos + 1;
      case (parse_phase)
         P_HEADER: begin
            if (pos < 3) begin
               if (b != (pos == 0 ? MAGIC_0 : (pos == 1 ? MAGIC_1 : MAGIC_2)))
                  close_tag(ST_NO_TAG);
            end else if (pos >= 6) begin
               tag_len = {tag_len[20:0], b[6:0]};
            end
            if (parse_phase == P_HEADER && pos == 9) begin
               if (tag_len == 0 || tag_len > max_tag) begin
                  close_tag(ST_BAD_SIZE);
               end else begin
                  parse_phase = P_HUNT;
                  win_fill    = '0;
               end
            end
         end
         P_HUNT: begin
            hdr_win[win_fill[2:0]] = b;
            win_fill = win_fill + 1;
            if (win_fill >= 8) begin
               fsize    = {hdr_win[4], hdr_win[5], hdr_win[6], hdr_win[7]};
               tag_stop = 64'd10 + tag_len;
               if (hdr_id_valid() && fsize != 0 && !fsize[31] && fsize[30:0] <= max_frame) begin
                  cur_tag      = hdr_id_word();
                  cur_class    = id_to_class(cur_tag);
                  payload_left = fsize;
                  payload_idx  = '0;
                  add_event(EV_FRAME_START, cur_tag, fsize[30:0], cur_class, 8'h00, 2'd0);
                  parse_phase = P_FLAGS;
                  win_fill    = '0;
               end else begin
                  // Slide the window by one byte.
                  for (int k = 0; k < 7; k++) hdr_win[k] = hdr_win[k+1];
                  hdr_win[7] = 8'h00;
                  win_fill   = 4'd7;
                  if ({32'd0, pos} - 64'd6 >= tag_stop) close_tag(end_status());
               end
            end
         end
         P_FLAGS: begin
            win_fill = win_fill + 1;
            if (win_fill >= 2) begin
               win_fill    = '0;
               parse_phase = P_PAYLOAD;
            end
         end
         P_PAYLOAD: begin
            total    = payload_left + payload_idx;
            tag_stop = 64'd10 + tag_len;
            if (cur_class == CL_COMMENT && total >= 4) begin
               kind = (payload_idx == 0) ? EV_ENCODING :
                      ((payload_idx < 4) ? EV_LANGUAGE : EV_TEXT);
               add_event(kind, cur_tag, total[30:0], cur_class, b, 2'd0);
            end else if (cur_class != CL_OTHER) begin
               if (payload_idx == 0)
                  add_event(EV_ENCODING, cur_tag, total[30:0], cur_class, b, 2'd0);
               else if (b != 8'h00)
                  add_event(EV_TEXT, cur_tag, total[30:0], cur_class, b, 2'd0);
            end
            payload_idx  = payload_idx + 1;
            payload_left = payload_left - 1;
            if (payload_left == 0) begin
               add_event(EV_FRAME_DONE, cur_tag, total[30:0], cur_class, 8'h00, 2'd0);
               frame_recorded = 1'b1;
               parse_phase    = P_HUNT;
               win_fill       = '0;
               if ({32'd0, pos} + 64'd1 >= tag_stop) close_tag(end_status());
            end
         end
         default: ;
      endcase
      if (eof) begin
         if (parse_phase == P_HEADER) close_tag(ST_NO_TAG);
         else if (parse_phase != P_DONE) close_tag(end_status());
         restart_file();
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $error("result word of kind %0d arrived with nothing expected", rsp_tuser);
            mismatches++;
         end else begin
            want = expected_events.pop_front();
            compare_field("event_kind", want.kind, rsp_tuser);
            compare_field("frame_tag", want.frame_tag, rsp_tdata[31:0]);
            compare_field("frame_bytes", want.frame_bytes, rsp_tdata[62:32]);
            compare_field("frame_class", want.frame_class, rsp_tdata[65:63]);
            compare_field("char_value", want.char_value, rsp_tdata[73:66]);
            compare_field("tag_status", want.tag_status, rsp_tdata[75:74]);
            compare_field("last", want.last, rsp_tlast);
            words_checked++;
            if (want.kind == EV_FRAME_DONE) frames_done++;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold) begin
            rsp_tready <= 1'b0;
            for (stall_count = 0; stall_count < HOLD_CYCLES; stall_count++) @(posedge clock);
            sink_hold = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                            input logic [1:0] typed_status);
      rsp_type ev;
      if ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (parse_phase != P_DONE) live_bytes++;
      parse_byte(b, eof);
      if (typed) begin
         ev            = '0;
         ev.kind       = EV_TAG_STATUS;
         ev.tag_status = typed_status;
         ev.last       = 1'b1;
         expected_events.push_back(ev);
      end else begin
         foreach (byte_events[i]) begin
            ev      = byte_events[i];
            ev.last = (i == byte_events.size() - 1);
            expected_events.push_back(ev);
         end
      end
   endtask

   // Stop sending and let every expected word and any trailing work come out.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_check(input logic reg_sel, input logic [31:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      compare_field("csr_prdata", want, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (reg_sel == REG_MAX_TAG) max_tag = value[27:0];
      else max_frame = value[30:0];
      csr_check(reg_sel, (reg_sel == REG_MAX_TAG) ? {4'd0, max_tag} : {1'b0, max_frame});
   endtask

   // ---------------------------------------------------------------- file generation

   function automatic void push_word(input logic [31:0] w);
      for (int k = 3; k >= 0; k--) tag_body.push_back(w[8*k +: 8]);
   endfunction

   task automatic build_file();
      int          shape;
      int          nfr;
      int          fsz;
      int          tsz;
      int          j;
      logic [31:0] fid;
      logic [31:0] fsize;
      logic [27:0] hdr_size;
      logic [3:0]  top_bits;
      logic [7:0]  pb;
      tag_body.delete();
      file_bytes.delete();
      shape = $urandom_range(99);
      if (shape < 10) begin
         // Plain noise, rarely a tag at all.
         repeat ($urandom_range(12, 1)) file_bytes.push_back($urandom_range(255));
      end else begin
         nfr = $urandom_range(3, 1);
         for (int f = 0; f < nfr; f++) begin
            case ($urandom_range(8))
               0: fid = ID_TIT2;
               1: fid = ID_TPE1;
               2: fid = ID_TALB;
               3: fid = ID_TYER;
               4: fid = ID_COMM;
               5: fid = ID_TCON;
               6: begin
                  fid[31:24] = $urandom_range(8'h5A, 8'h41);
                  for (int k = 0; k < 3; k++)
                     fid[8*k +: 8] = $urandom_range(1) ? $urandom_range(8'h5A, 8'h41) :
                                                         $urandom_range(8'h39, 8'h30);
               end
               7: begin
                  // Short ID: a zero ends it, whatever follows.
                  fid = $urandom;
                  fid[31:24] = $urandom_range(8'h5A, 8'h41);
                  j = $urandom_range(3, 1);
                  fid[31-8*j -: 8] = 8'h00;
               end
               default: fid = $urandom;
            endcase
            fsz = (fid == ID_COMM) ? $urandom_range(9, 1) : $urandom_range(5, 1);
            if (fsz > max_frame && $urandom_range(3) != 0) fsz = max_frame;
            fsize = fsz;
            if ($urandom_range(19) == 0) begin
               case ($urandom_range(2))
                  0: fsize = 32'h0000_0000;
                  1: fsize = 32'h7FFF_FFFF;
                  default: fsize = 32'h8000_0000;
               endcase
            end
            push_word(fid);
            push_word(fsize);
            tag_body.push_back($urandom_range(255));
            tag_body.push_back($urandom_range(255));
            repeat (fsz) begin
               pb = $urandom_range(255);
               if ($urandom_range(3) == 0) pb = 8'h00;
               tag_body.push_back(pb);
            end
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(3, 1)) tag_body.push_back($urandom_range(255));
         end
         repeat ($urandom_range(3)) tag_body.push_back(8'h00);
         tsz = tag_body.size();
         if ($urandom_range(4) == 0) tsz = $urandom_range(tsz, 1);
         if (tsz > max_tag && $urandom_range(3) != 0) tsz = max_tag;
         if (shape >= 14 && shape < 18) tsz = $urandom_range(1) ? 0 : max_tag + 1;
         else if (shape >= 18 && shape < 20) tsz = 28'h0FFF_FFFF;
         hdr_size = tsz;
         top_bits = $urandom_range(15);
         file_bytes.push_back(MAGIC_0);
         file_bytes.push_back(MAGIC_1);
         file_bytes.push_back(MAGIC_2);
         repeat (3) file_bytes.push_back($urandom_range(255));
         file_bytes.push_back({top_bits[3], hdr_size[27:21]});
         file_bytes.push_back({top_bits[2], hdr_size[20:14]});
         file_bytes.push_back({top_bits[1], hdr_size[13:7]});
         file_bytes.push_back({top_bits[0], hdr_size[6:0]});
         if (shape >= 10 && shape < 14) begin
            j = $urandom_range(2);
            file_bytes[j] = file_bytes[j] ^ $urandom_range(255, 1);
         end
         foreach (tag_body[k]) file_bytes.push_back(tag_body[k]);
         repeat ($urandom_range(2)) file_bytes.push_back($urandom_range(255));
         // Some files are cut short, often in the middle of a frame.
         if ($urandom_range(6) == 0) begin
            j = $urandom_range(file_bytes.size(), 1);
            while (file_bytes.size() > j) void'(file_bytes.pop_back());
         end
      end
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      logic [31:0] frame_limit;
      logic [31:0] tag_limit;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 8'h00;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      sink_hold     = 1'b0;
      mismatches    = 0;
      words_checked = 0;
      frames_done   = 0;
      files_sent    = 0;
      bytes_sent    = 0;
      max_frame     = MAX_FRAME_RESET;
      max_tag       = MAX_TAG_RESET;
      restart_file();
      // Wrong magic, zero tag size, end of file inside the header, empty tag of size one.
      directed_rows = '{
         {"X",     1'b1, 1'b1, ST_NO_TAG},
         {MAGIC_0, 1'b0, 1'b0, ST_OK},
         {MAGIC_1, 1'b0, 1'b0, ST_OK},
         {MAGIC_2, 1'b0, 1'b0, ST_OK},
         {8'hFF,   1'b0, 1'b0, ST_OK},
         {8'hFF,   1'b0, 1'b0, ST_OK},
         {8'hFF,   1'b0, 1'b0, ST_OK},
         {8'h80,   1'b0, 1'b0, ST_OK},
         {8'h80,   1'b0, 1'b0, ST_OK},
         {8'h80,   1'b0, 1'b0, ST_OK},
         {8'h80,   1'b1, 1'b1, ST_BAD_SIZE},
         {MAGIC_0, 1'b0, 1'b0, ST_OK},
         {MAGIC_1, 1'b1, 1'b1, ST_NO_TAG},
         {MAGIC_0, 1'b0, 1'b0, ST_OK},
         {MAGIC_1, 1'b0, 1'b0, ST_OK},
         {MAGIC_2, 1'b0, 1'b0, ST_OK},
         {8'h00,   1'b0, 1'b0, ST_OK},
         {8'h00,   1'b0, 1'b0, ST_OK},
         {8'h00,   1'b0, 1'b0, ST_OK},
         {8'h00,   1'b0, 1'b0, ST_OK},
         {8'h00,   1'b0, 1'b0, ST_OK},
         {8'h00,   1'b0, 1'b0, ST_OK},
         {8'h01,   1'b0, 1'b0, ST_OK},
         {"Z",     1'b1, 1'b1, ST_NO_FRAMES}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(REG_MAX_FRAME, {1'b0, MAX_FRAME_RESET});
      csr_check(REG_MAX_TAG, {4'd0, MAX_TAG_RESET});

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].eof, directed_rows[i].typed,
                   directed_rows[i].status);
         if (directed_rows[i].eof) files_sent++;
      end

      for (int p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: begin
               frame_limit = {1'b0, MAX_SIZE_MASK};
               tag_limit   = 32'h0FFF_FFFF;
            end
            1: begin
               frame_limit = 32'd5;
               tag_limit   = 32'd40;
            end
            2: begin
               frame_limit = 32'd1;
               tag_limit   = 32'd1;
            end
            default: begin
               frame_limit = 32'd300;
               tag_limit   = 32'd600;
            end
         endcase
         csr_write(REG_MAX_FRAME, frame_limit);
         csr_write(REG_MAX_TAG, tag_limit);
         src_idle_pct  = (p == 0) ? 35 : ((p == 1) ? 69 : 0);
         sink_idle_pct = (p == 0) ? 69 : ((p == 1) ? 35 : 0);
         // A long result stall while the input keeps coming fills the block up.
         if (p == 2) sink_hold = 1'b1;
         live_bytes = 0;
         while (live_bytes < PHASE_BYTES) begin
            build_file();
            foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1,
                                              1'b0, ST_OK);
            files_sent++;
         end
      end
      drain();

      $display("Sent %0d files in %0d bytes; checked %0d result words, %0d complete frames.",
               files_sent, bytes_sent, words_checked, frames_done);
      $display("Size limits went from one byte to full range, with three stall patterns.");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
